@@ design/wwa_pkg.sv @@
// Package for the weighted window average alarm.
// Holds the shared constants, codes, state type and rate tables.
// No dependencies.
package wwa_pkg;

	localparam int WINDOW_DEF = 12;
	localparam int TEMP_W     = 16;
	localparam int RATE_W     = 5;
	localparam int OP_W       = 2;
	localparam int COPY_W     = 3;
	localparam int CFG_AW     = 3;
	localparam int CFG_DW     = 32;
	localparam int OUT_DW     = 24;

	localparam logic signed [TEMP_W-1:0] THRESHOLD_RST = 16'sd10240;

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE = 2'd0,
		OP_BUTTON = 2'd1,
		OP_TICK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic {
		KIND_RATE   = 1'b0,
		KIND_REPORT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		MODE_5S  = 2'd0,
		MODE_15S = 2'd1,
		MODE_30S = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_WR,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd0;

	function automatic logic [RATE_W-1:0] rate_of(input mode_t m);
		logic [RATE_W-1:0] r;
		case (m)
			MODE_5S:  r = 5'd5;
			MODE_15S: r = 5'd15;
			default:  r = 5'd30;
		endcase
		return r;
	endfunction

	function automatic logic [COPY_W-1:0] copies_of(input mode_t m);
		logic [COPY_W-1:0] c;
		case (m)
			MODE_5S:  c = 3'd1;
			MODE_15S: c = 3'd3;
			default:  c = 3'd6;
		endcase
		return c;
	endfunction

	function automatic mode_t mode_next(input mode_t m);
		mode_t n;
		case (m)
			MODE_5S:  n = MODE_15S;
			MODE_15S: n = MODE_30S;
			default:  n = MODE_5S;
		endcase
		return n;
	endfunction

endpackage

@@ design/wwa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the sample window. No dependencies.
module wwa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/weighted_window_average_alarm.sv @@
// Top level of the weighted window average alarm.
// Depends on wwa_pkg and wwa_ram.
//
// One item at a time. Sample: each window write is a read-modify-write of the
// window RAM (ST_RD then ST_WR). Button: result is loaded in ST_EMIT. Tick:
// ST_DIV, ST_FIN then ST_EMIT (straight to ST_EMIT on an empty window), set by
// the one-bit-per-cycle divider. Asynchronous reset clears the pointer, count,
// sum, rate mode and output valid and loads the threshold with 10240.
module weighted_window_average_alarm #(
	parameter int WINDOW = wwa_pkg::WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wwa_pkg::CFG_AW-1:0]  paddr,
	input  logic [wwa_pkg::CFG_DW-1:0]  pwdata,
	output logic [wwa_pkg::CFG_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [15:0] temperature
	input  logic [wwa_pkg::TEMP_W-1:0]  s_tdata,
	// [1:0] op
	input  logic [wwa_pkg::OP_W-1:0]    s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [4:0] rate_seconds, [20:5] average, [21] alert, [22] no_data, [23] zero
	output logic [wwa_pkg::OUT_DW-1:0]  m_tdata,
	// [0] kind
	output logic                        m_tuser
);
	import wwa_pkg::*;

	localparam int PTR_W = $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = TEMP_W + $clog2(WINDOW);
	localparam int DIV_W = $clog2(SUM_W);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);

	state_t                    state_q, state_d;
	mode_t                     mode_q;
	logic [PTR_W-1:0]          ptr_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [TEMP_W-1:0]  thr_q;
	logic signed [TEMP_W-1:0]  temp_q;
	logic [COPY_W-1:0]         copies_q;
	logic [SUM_W-1:0]          quo_q;
	logic [CNT_W-1:0]          rem_q;
	logic                      neg_q;
	logic [DIV_W-1:0]          div_cnt_q;
	logic                      res_kind_q;
	logic [RATE_W-1:0]         res_rate_q;
	logic signed [TEMP_W-1:0]  res_avg_q;
	logic                      res_nodata_q;
	logic                      out_kind_q;
	logic [RATE_W-1:0]         out_rate_q;
	logic signed [TEMP_W-1:0]  out_avg_q;
	logic                      out_alert_q;
	logic                      out_nodata_q;
	logic                      out_valid_q;

	logic                      s_xfer, cfg_wr, full, ram_re, ram_we, out_load, out_free;
	logic [TEMP_W-1:0]         ram_rdata;
	logic signed [SUM_W-1:0]   old_ext, sum_next;
	logic [CNT_W:0]            rem_sh;
	logic                      rem_ge;
	logic [SUM_W-1:0]          quo_neg;
	op_t                       op_in;

	assign op_in    = op_t'(s_tuser);
	assign s_xfer   = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = (paddr[CFG_AW-1] == REG_THRESHOLD[CFG_AW-1]) ?
	                  {{(CFG_DW-TEMP_W){thr_q[TEMP_W-1]}}, thr_q} : '0;
	assign full     = (cnt_q == CNT_FULL);
	assign out_free = !out_valid_q || m_tready;

	assign old_ext  = full ? SUM_W'(signed'(ram_rdata)) : '0;
	assign sum_next = sum_q + SUM_W'(temp_q) - old_ext;
	assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
	assign rem_ge   = (rem_sh >= {1'b0, cnt_q});
	assign quo_neg  = neg_q ? (~quo_q + 1'b1) : quo_q;

	wwa_ram #(
		.WIDTH(TEMP_W),
		.DEPTH(WINDOW)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ptr_q),
		.wdata(temp_q),
		.re   (ram_re),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (op_in)
						OP_SAMPLE: state_d = ST_RD;
						OP_BUTTON: state_d = ST_EMIT;
						OP_TICK:   state_d = (cnt_q == '0) ? ST_EMIT : ST_DIV;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD: begin
				ram_re  = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				ram_we  = 1'b1;
				state_d = (copies_q == COPY_W'(1)) ? ST_IDLE : ST_RD;
			end
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_5S;
			ptr_q       <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			thr_q       <= THRESHOLD_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && paddr[CFG_AW-1] == REG_THRESHOLD[CFG_AW-1]) begin
				thr_q <= pwdata[TEMP_W-1:0];
			end
			if (s_xfer && op_in == OP_BUTTON) begin
				mode_q <= mode_next(mode_q);
			end
			if (state_q == ST_WR) begin
				sum_q <= sum_next;
				ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
				if (!full) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			temp_q       <= s_tdata;
			copies_q     <= copies_of(mode_q);
			res_kind_q   <= (op_in == OP_BUTTON) ? KIND_RATE : KIND_REPORT;
			res_rate_q   <= (op_in == OP_BUTTON) ? rate_of(mode_q) : '0;
			res_avg_q    <= '0;
			res_nodata_q <= (op_in == OP_TICK) && (cnt_q == '0);
			neg_q        <= sum_q[SUM_W-1];
			quo_q        <= sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
			rem_q        <= '0;
			div_cnt_q    <= DIV_W'(SUM_W - 1);
		end
		if (state_q == ST_WR) begin
			copies_q <= copies_q - 1'b1;
		end
		if (state_q == ST_DIV) begin
			rem_q     <= rem_ge ? CNT_W'(rem_sh - {1'b0, cnt_q}) : rem_sh[CNT_W-1:0];
			quo_q     <= {quo_q[SUM_W-2:0], rem_ge};
			div_cnt_q <= div_cnt_q - 1'b1;
		end
		if (state_q == ST_FIN) begin
			res_avg_q <= quo_neg[TEMP_W-1:0];
		end
		if (out_load) begin
			out_kind_q   <= res_kind_q;
			out_rate_q   <= res_rate_q;
			out_avg_q    <= res_avg_q;
			out_nodata_q <= res_nodata_q;
			out_alert_q  <= (res_kind_q == KIND_REPORT) && !res_nodata_q &&
			                (res_avg_q >= thr_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {1'b0, out_nodata_q, out_alert_q, out_avg_q, out_rate_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("valid count above window depth");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_LAST)
		else $error("write pointer out of range");

	a_ptr_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		!full && (state_q == ST_IDLE) |-> (CNT_W'(ptr_q) == cnt_q))
		else $error("pointer and count disagree before the window fills");

	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_REPORT && m_tdata[22] |->
		(m_tdata[20:5] == '0) && !m_tdata[21])
		else $error("empty-window report carries an average or alert");

	a_rate_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_RATE |->
		(m_tdata[4:0] == 5'd5) || (m_tdata[4:0] == 5'd15) || (m_tdata[4:0] == 5'd30))
		else $error("rate announcement with a bad rate");

endmodule
